// ===== sv/lzr_pkg.sv =====
package lzr_pkg;

    // Ring geometry (fixed by the stream format)
    localparam int RING_DEPTH = 4096;
    localparam int RING_AW    = 12;
    localparam int FILL_W     = RING_AW + 1;

    // Match length field: 4 bits plus the minimum length
    localparam int LEN_W     = 5;
    localparam int MATCH_MIN = 3;

    localparam int CNT_W     = 32;

    typedef logic [7:0]         t_byte;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [RING_AW-1:0] t_ring_addr;
    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [LEN_W-1:0]   t_len;

    localparam t_byte RING_FILL   = 8'h20;
    localparam t_byte FLAG_MARKER = 8'hff;

    // Token decode phase
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_FIRST = 2'd1,
        PH_HIGH  = 2'd2
    } t_phase;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_COPY = 1'b1
    } t_state;

    // Configuration register indexes
    typedef enum logic {
        CFG_EXPECTED_SIZE = 1'b0,
        CFG_PREFIX_LIMIT  = 1'b1
    } t_cfg_idx;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic stage_free;
        logic dec_match;
        logic rem_one;
    } t_sts;

endpackage

// ===== sv/lzr_ifs.sv =====
// Compressed byte channel
interface lzr_in_if;
    logic           valid;
    logic           ready;
    lzr_pkg::t_byte in_byte;
    logic           in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decompressed result channel
interface lzr_out_if;
    logic           valid;
    logic           ready;
    lzr_pkg::t_byte out_byte;
    logic           byte_valid;
    logic           out_last;
    logic           size_error;

    modport source (output valid, output out_byte, output byte_valid, output out_last,
                    output size_error, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                    input size_error, output ready);
endinterface

// Configuration write channel
interface lzr_cfg_if;
    logic                valid;
    logic                ready;
    lzr_pkg::t_cfg_idx   index;
    lzr_pkg::t_cnt       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/lzss_ring_decompressor.sv =====
// LZSS decompressor with a 4096-byte history ring.
// i_in takes one compressed byte per transfer, in_last on the final byte of a
// stream. o_out gives one result per transfer: a decompressed byte
// (byte_valid 1) or, when the final input yields no byte, a status-only
// result. out_last and size_error ride on the final result of a stream.
// i_cfg writes expected_size (index 0) and prefix_limit (index 1); write it
// only between streams. It is always ready.
// Flag and match low bytes give no result unless final; a match high byte
// gives L output bytes (up to 18), one ring read a cycle while the stage is free.
// A literal reaches o_out through the stage entry and the output register;
// a match byte through the ring read with its stage entry, then the output register.
// The ring is not cleared: a fill count marks the entries written in the
// current stream and all others read as spaces, so a new stream may start
// the cycle after the previous stream has ended. Reset (synchronous,
// active low) returns the stream state and both registers to their defaults.
// A stalled receiver holds the output register and one stage behind it; the
// block then stops taking input and ring reads until the result is taken.
module lzss_ring_decompressor #(
    parameter int LOOKAHEAD = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzr_in_if.sink     i_in,
    lzr_out_if.source  o_out,
    lzr_cfg_if.sink    i_cfg
);

    lzr_pkg::t_cmd w_cmd;
    lzr_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_in.ready = w_in_ready;

    lzr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    lzr_datapath #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_byte (i_in.in_byte),
        .i_in_last (i_in.in_last),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_out     (o_out),
        .i_cfg     (i_cfg)
    );

endmodule

// ===== sv/lzr_ctrl.sv =====
module lzr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lzr_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output lzr_pkg::t_cmd o_cmd
);

    lzr_pkg::t_state r_state;
    lzr_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.issue  = 1'b0;
        unique case (r_state)
            lzr_pkg::ST_IDLE: begin
                o_in_ready   = i_sts.stage_free;
                o_cmd.accept = i_sts.stage_free && i_in_valid;
                if (o_cmd.accept && i_sts.dec_match) begin
                    n_state = lzr_pkg::ST_COPY;
                end
            end
            lzr_pkg::ST_COPY: begin
                // one ring read per cycle while the stage can take it
                o_cmd.issue = i_sts.stage_free;
                if (o_cmd.issue && i_sts.rem_one) begin
                    n_state = lzr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lzr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/lzr_datapath.sv =====
module lzr_datapath #(
    parameter int LOOKAHEAD = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lzr_pkg::t_byte i_in_byte,
    input  logic           i_in_last,
    input  lzr_pkg::t_cmd  i_cmd,
    output lzr_pkg::t_sts  o_sts,
    lzr_out_if.source      o_out,
    lzr_cfg_if.sink        i_cfg
);

    localparam lzr_pkg::t_ring_addr WP_INIT =
        lzr_pkg::RING_AW'((lzr_pkg::RING_DEPTH - LOOKAHEAD) % lzr_pkg::RING_DEPTH);
    localparam lzr_pkg::t_fill FILL_FULL = lzr_pkg::FILL_W'(lzr_pkg::RING_DEPTH);

    // Configuration
    lzr_pkg::t_cnt r_exp;
    lzr_pkg::t_cnt r_pre;

    // Stream state
    lzr_pkg::t_phase     r_phase;
    lzr_pkg::t_phase     n_phase;
    logic [15:0]         r_flags;
    logic [15:0]         n_flags;
    lzr_pkg::t_byte      r_low;
    lzr_pkg::t_byte      n_low;
    lzr_pkg::t_cnt       r_count;
    lzr_pkg::t_ring_addr r_wp;
    lzr_pkg::t_fill      r_fill;

    // Match copy state
    lzr_pkg::t_ring_addr r_pos;
    lzr_pkg::t_len       r_rem;
    logic                r_m_last;

    // Stage entry
    logic            r_s_v;
    logic            r_s_mem;
    logic            r_s_ok;
    logic            r_s_bv;
    logic            r_s_last;
    logic            r_s_err;
    lzr_pkg::t_byte  r_s_lit;
    lzr_pkg::t_byte  s_data;

    // Ring memory and read bypass
    lzr_pkg::t_byte  r_ring [lzr_pkg::RING_DEPTH];
    lzr_pkg::t_byte  r_rdata;
    logic            r_byp;
    lzr_pkg::t_byte  r_byp_data;

    // Output register
    logic            r_o_v;
    lzr_pkg::t_byte  r_o_byte;
    logic            r_o_bv;
    logic            r_o_last;
    logic            r_o_err;

    // Decode helpers
    lzr_pkg::t_cnt       limit;
    lzr_pkg::t_cnt       room;
    lzr_pkg::t_cnt       cnt_inc;
    logic                active;
    logic                chk_en;
    lzr_pkg::t_len       len;
    lzr_pkg::t_len       rem_dec;
    logic [15:0]         f_shift;
    logic                first;
    logic                tf_bit;
    logic                lit;
    logic                dec_match;
    logic                acc_load;
    logic                s_adv;
    logic                we;
    logic                stream_rst;
    logic                in_range;
    lzr_pkg::t_ring_addr rd_off;

    // Limit and size check
    assign limit   = (r_exp < r_pre) ? r_exp : r_pre;
    assign active  = r_count < limit;
    assign room    = limit - r_count;
    assign cnt_inc = r_count + lzr_pkg::CNT_W'(1);
    assign chk_en  = r_pre >= r_exp;

    // Match length clipped to the bytes left before the limit
    assign len     = lzr_pkg::LEN_W'(i_in_byte[3:0]) + lzr_pkg::LEN_W'(lzr_pkg::MATCH_MIN);
    assign rem_dec = (room < lzr_pkg::CNT_W'(len)) ? room[lzr_pkg::LEN_W-1:0] : len;
    assign f_shift = r_flags >> 1;

    assign dec_match = active && (r_phase == lzr_pkg::PH_HIGH);

    // Token decode for an accepted byte
    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_low   = r_low;
        first   = 1'b0;
        tf_bit  = 1'b0;
        lit     = 1'b0;
        if (active) begin
            case (r_phase)
                lzr_pkg::PH_FIRST: begin
                    first  = 1'b1;
                    tf_bit = r_flags[0];
                end
                lzr_pkg::PH_HIGH: begin
                    n_phase = lzr_pkg::PH_START;
                end
                default: begin
                    // marker bit exhausted: this byte is a new flag byte
                    if (!f_shift[8]) begin
                        n_flags = {lzr_pkg::FLAG_MARKER, i_in_byte};
                        n_phase = lzr_pkg::PH_FIRST;
                    end else begin
                        n_flags = f_shift;
                        first   = 1'b1;
                        tf_bit  = f_shift[0];
                    end
                end
            endcase
        end
        if (first) begin
            if (tf_bit) begin
                lit     = 1'b1;
                n_phase = lzr_pkg::PH_START;
            end else begin
                n_low   = i_in_byte;
                n_phase = lzr_pkg::PH_HIGH;
            end
        end
    end

    // Stage and output movement
    assign s_adv    = r_s_v && (!r_o_v || o_out.ready);
    assign acc_load = i_cmd.accept && (lit || (i_in_last && !dec_match));
    assign s_data   = !r_s_mem ? r_s_lit : (r_byp ? r_byp_data : (r_s_ok ? r_rdata
                                                                          : lzr_pkg::RING_FILL));
    assign we       = s_adv && r_s_bv && !r_s_last;

    assign stream_rst = (i_cmd.accept && i_in_last && !dec_match) ||
                        (i_cmd.issue && (r_rem == lzr_pkg::LEN_W'(1)) && r_m_last);

    // Entry written since the stream began, per the fill count
    assign rd_off   = r_pos - WP_INIT;
    assign in_range = {1'b0, rd_off} < r_fill;

    assign o_sts.stage_free = !r_s_v || s_adv;
    assign o_sts.dec_match  = dec_match;
    assign o_sts.rem_one    = r_rem == lzr_pkg::LEN_W'(1);

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_pre <= '1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lzr_pkg::CFG_EXPECTED_SIZE: r_exp <= i_cfg.data;
                lzr_pkg::CFG_PREFIX_LIMIT:  r_pre <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stream state; end of stream returns it to the start values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || stream_rst) begin
            r_phase <= lzr_pkg::PH_START;
            r_flags <= '0;
            r_low   <= '0;
            r_count <= '0;
            r_wp    <= WP_INIT;
            r_fill  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_phase <= n_phase;
                r_flags <= n_flags;
                r_low   <= n_low;
            end
            if ((i_cmd.accept && lit) || i_cmd.issue) begin
                r_count <= cnt_inc;
            end
            if (we) begin
                r_wp <= r_wp + lzr_pkg::RING_AW'(1);
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + lzr_pkg::FILL_W'(1);
                end
            end
        end
    end

    // Match copy counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_cmd.accept && dec_match) begin
            r_rem <= rem_dec;
        end else if (i_cmd.issue) begin
            r_rem <= r_rem - lzr_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && dec_match) begin
            r_pos    <= {i_in_byte[7:4], r_low};
            r_m_last <= i_in_last;
        end else if (i_cmd.issue) begin
            r_pos <= r_pos + lzr_pkg::RING_AW'(1);
        end
    end

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ring[r_wp] <= s_data;
        end
        if (i_cmd.issue) begin
            r_rdata <= r_ring[r_pos];
        end
    end

    // Forward the byte written in the same cycle as its read
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_byp      <= we && (r_wp == r_pos);
            r_byp_data <= s_data;
        end
    end

    // Stage entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (acc_load || i_cmd.issue) begin
            r_s_v <= 1'b1;
        end else if (s_adv) begin
            r_s_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_load) begin
            r_s_mem  <= 1'b0;
            r_s_ok   <= 1'b0;
            r_s_bv   <= lit;
            r_s_lit  <= lit ? i_in_byte : '0;
            r_s_last <= i_in_last;
            r_s_err  <= chk_en && ((lit ? cnt_inc : r_count) != r_exp);
        end else if (i_cmd.issue) begin
            r_s_mem  <= 1'b1;
            r_s_ok   <= in_range;
            r_s_bv   <= 1'b1;
            r_s_lit  <= '0;
            r_s_last <= r_m_last && (r_rem == lzr_pkg::LEN_W'(1));
            r_s_err  <= chk_en && (cnt_inc != r_exp);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s_adv) begin
            r_o_v <= 1'b1;
        end else if (o_out.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_o_byte <= s_data;
            r_o_bv   <= r_s_bv;
            r_o_last <= r_s_last;
            r_o_err  <= r_s_last && r_s_err;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.out_byte   = r_o_byte;
    assign o_out.byte_valid = r_o_bv;
    assign o_out.out_last   = r_o_last;
    assign o_out.size_error = r_o_err;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int   RING_START     = lzr_pkg::RING_DEPTH - 18;   // write pointer after reset
    localparam lzr_pkg::t_cnt CNT_MAX = '1;
    localparam int   RANDOM_CODES   = 320;
    localparam int   MAX_WAIT       = 19;
    localparam int   CFG_SETTLE     = 4;                // wait after the last result before a register write
    localparam int   DRAIN_CYCLES   = 40;
    localparam int   RX_HOLD_CYCLES = 300;
    // Longest quiet stretch in a good run is the receiver hold; leave ample margin
    localparam int   WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        lzr_pkg::t_byte data;
        logic           has_data;
        logic           last;
        logic           err;
    } t_res;

    typedef struct packed {
        lzr_pkg::t_byte b;
        logic           last;
    } t_code;

    typedef enum {CUT_NONE, CUT_AFTER_FLAG, CUT_AFTER_LOW} t_cut;
    typedef enum {SZ_EXACT, SZ_SHORT, SZ_OVER, SZ_PREFIX, SZ_EXTREME, SZ_EQUAL} t_size_mode;

    logic i_clk;
    logic i_rst_n;

    lzr_in_if  in_if();
    lzr_out_if out_if();
    lzr_cfg_if cfg_if();

    lzss_ring_decompressor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Decoder state as seen by the predictor
    lzr_pkg::t_byte      ring [lzr_pkg::RING_DEPTH];
    lzr_pkg::t_ring_addr wr_ptr;
    logic [15:0]         flag_bits;
    lzr_pkg::t_phase     tok_phase;
    lzr_pkg::t_byte      match_lo;
    lzr_pkg::t_cnt       emitted;
    lzr_pkg::t_cnt       reg_expected;
    lzr_pkg::t_cnt       reg_prefix;
    int                  step_results;

    t_res  pending_out[$];
    t_code gen_q[$];
    int    gen_count;

    // Shared run control and bookkeeping
    bit no_gaps = 1'b0;
    int rx_hold = 0;
    int fails = 0;
    int codes_sent = 0;
    int streams_run = 0;
    int results_seen = 0;
    int status_seen = 0;
    int size_err_seen = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic void clear_stream();
        for (int i = 0; i < lzr_pkg::RING_DEPTH; i++) ring[i] = lzr_pkg::RING_FILL;
        wr_ptr    = lzr_pkg::t_ring_addr'(RING_START);
        flag_bits = '0;
        tok_phase = lzr_pkg::PH_START;
        match_lo  = '0;
        emitted   = '0;
    endfunction

    function automatic void add_result(t_res r);
        pending_out.insert(pending_out.size(), r);
    endfunction

    function automatic void emit_byte(lzr_pkg::t_byte v);
        t_res r;
        r.data     = v;
        r.has_data = 1'b1;
        r.last     = 1'b0;
        r.err      = 1'b0;
        add_result(r);
        ring[wr_ptr] = v;
        wr_ptr++;
        emitted++;
        step_results++;
    endfunction

    // Byte after a flag byte or a finished token: literal or match low byte
    function automatic void token_head(lzr_pkg::t_byte b);
        if (flag_bits[0]) begin
            emit_byte(b);
            tok_phase = lzr_pkg::PH_START;
        end else begin
            match_lo  = b;
            tok_phase = lzr_pkg::PH_HIGH;
        end
    endfunction

    function automatic void decode_byte(lzr_pkg::t_byte b, logic last);
        lzr_pkg::t_cnt       lim;
        lzr_pkg::t_ring_addr pos;
        int                  len;
        logic [15:0]         f;
        t_res                r;
        lim = (reg_expected < reg_prefix) ? reg_expected : reg_prefix;
        step_results = 0;
        if (emitted < lim) begin
            case (tok_phase)
                lzr_pkg::PH_FIRST: token_head(b);
                lzr_pkg::PH_HIGH: begin
                    pos = {b[7:4], match_lo};
                    len = int'(b[3:0]) + lzr_pkg::MATCH_MIN;
                    for (int i = 0; i < len && emitted < lim; i++) begin
                        emit_byte(ring[pos]);
                        pos++;
                    end
                    tok_phase = lzr_pkg::PH_START;
                end
                default: begin
                    f = flag_bits >> 1;
                    if (!f[8]) begin
                        flag_bits = {lzr_pkg::FLAG_MARKER, b};
                        tok_phase = lzr_pkg::PH_FIRST;
                    end else begin
                        flag_bits = f;
                        token_head(b);
                    end
                end
            endcase
        end
        if (last) begin
            // no byte from the final input: a status-only result carries the flags
            if (step_results == 0) begin
                r = '0;
                add_result(r);
            end
            pending_out[pending_out.size() - 1].last = 1'b1;
            pending_out[pending_out.size() - 1].err  =
                (reg_prefix >= reg_expected) && (emitted != reg_expected);
            clear_stream();
        end
    endfunction

    // ---------------- stream builder ----------------

    function automatic void push_code(lzr_pkg::t_byte b, logic last = 1'b0);
        t_code c;
        c.b    = b;
        c.last = last;
        gen_q.insert(gen_q.size(), c);
    endfunction

    function automatic void end_stream();
        gen_q[gen_q.size() - 1].last = 1'b1;
    endfunction

    // Stream of ntok tokens, rounded up to a multiple of 8 if cut; gen_count: bytes it decodes to
    function automatic void build_stream(int ntok, t_cut cut);
        int                  made;
        int                  len;
        lzr_pkg::t_byte      flag_b;
        lzr_pkg::t_ring_addr wp;
        lzr_pkg::t_ring_addr pos;
        gen_q.delete();
        gen_count = 0;
        made = 0;
        wp = lzr_pkg::t_ring_addr'(RING_START);
        // truncation needs a token boundary at a flag byte
        if (cut != CUT_NONE) ntok = (ntok + 7) / 8 * 8;
        while (made < ntok) begin
            flag_b = ($urandom_range(0, 3) == 0) ? lzr_pkg::FLAG_MARKER
                                                 : lzr_pkg::t_byte'($urandom);
            push_code(flag_b);
            for (int k = 0; k < 8 && made < ntok; k++) begin
                if (flag_b[k]) begin
                    push_code(lzr_pkg::t_byte'($urandom));
                    wp++;
                    gen_count++;
                end else begin
                    len = $urandom_range(lzr_pkg::MATCH_MIN, lzr_pkg::MATCH_MIN + 15);
                    // mostly recent history, including overlapping copies
                    if ($urandom_range(0, 3) != 0)
                        pos = wp - lzr_pkg::t_ring_addr'($urandom_range(1, 64));
                    else
                        pos = lzr_pkg::t_ring_addr'($urandom);
                    push_code(pos[7:0]);
                    push_code({pos[11:8], 4'(len - lzr_pkg::MATCH_MIN)});
                    wp += lzr_pkg::t_ring_addr'(len);
                    gen_count += len;
                end
                made++;
            end
        end
        if (cut == CUT_AFTER_FLAG) begin
            push_code(lzr_pkg::t_byte'($urandom));
        end else if (cut == CUT_AFTER_LOW) begin
            flag_b = lzr_pkg::t_byte'($urandom);
            flag_b[0] = 1'b0;
            push_code(flag_b);
            push_code(lzr_pkg::t_byte'($urandom));
        end
        end_stream();
    endfunction

    // ---------------- drivers ----------------

    task automatic send_code(t_code c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= c.b;
        in_if.in_last <= c.last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        decode_byte(c.b, c.last);
        codes_sent++;
    endtask

    task automatic run_stream();
        foreach (gen_q[i]) send_code(gen_q[i]);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        streams_run++;
    endtask

    // Register writes only with the block idle
    task automatic set_sizes(lzr_pkg::t_cnt exp_size, lzr_pkg::t_cnt pre_lim);
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= lzr_pkg::CFG_EXPECTED_SIZE;
        cfg_if.data  <= exp_size;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        reg_expected = exp_size;
        cfg_if.index <= lzr_pkg::CFG_PREFIX_LIMIT;
        cfg_if.data  <= pre_lim;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        reg_prefix = pre_lim;
        cfg_if.valid <= 1'b0;
    endtask

    // Receiver: random stall per result, plus a long hold when requested
    initial begin : rx_side
        int stall;
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid === 1'b1 && i_rst_n === 1'b1));
        end
    end

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin : chk
        t_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (!out_if.byte_valid) status_seen++;
            if (out_if.size_error) size_err_seen++;
            if (pending_out.size() == 0) begin
                $error("result with nothing pending: out_byte %h byte_valid %b out_last %b",
                       out_if.out_byte, out_if.byte_valid, out_if.out_last);
                fails++;
            end else begin
                want = pending_out.pop_front();
                if (out_if.out_byte !== want.data) begin
                    $error("out_byte: expected %h, got %h", want.data, out_if.out_byte);
                    fails++;
                end
                if (out_if.byte_valid !== want.has_data) begin
                    $error("byte_valid: expected %b, got %b", want.has_data, out_if.byte_valid);
                    fails++;
                end
                if (out_if.out_last !== want.last) begin
                    $error("out_last: expected %b, got %b", want.last, out_if.out_last);
                    fails++;
                end
                if (out_if.size_error !== want.err) begin
                    $error("size_error: expected %b, got %b", want.err, out_if.size_error);
                    fails++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** lzss_ring_decompressor: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- tests ----------------

    // Register defaults: limit 0, every byte is dropped, only the status result appears
    task automatic test_reset_registers();
        gen_q.delete();
        push_code(8'hff);
        push_code(8'h20, 1'b1);
        run_stream();
    endtask

    // Literals at both extremes, overlapping 18-byte copy, 3-byte copies, unwritten ring
    task automatic test_token_kinds();
        set_sizes(27, CNT_MAX);
        gen_q.delete();
        push_code(8'h0b);
        push_code(8'h00);
        push_code(8'hff);
        push_code(8'hef);           // copy from 4079, one behind the write pointer
        push_code(8'hff);           // length 18
        push_code(8'h41);
        push_code(8'h00);           // copy from 0, wrapped history
        push_code(8'h00);
        push_code(8'h00);           // copy from 0x800, never written: spaces
        push_code(8'h80, 1'b1);
        run_stream();
    endtask

    // Short streams and streams cut inside a token
    task automatic test_short_streams();
        set_sizes(3, 3);
        gen_q.delete();
        push_code(8'h01);
        push_code(8'h7e, 1'b1);
        run_stream();
        gen_q.delete();
        push_code(8'h5c, 1'b1);     // ends on the flag byte
        run_stream();
        gen_q.delete();
        push_code(8'hfe);
        push_code(8'h34, 1'b1);     // ends on a match low byte
        run_stream();
    endtask

    // Copy cut at the limit, later bytes ignored; prefix below expected size
    task automatic test_output_limit();
        set_sizes(5, CNT_MAX);
        gen_q.delete();
        push_code(8'h00);
        push_code(8'hee);
        push_code(8'h0f);
        push_code(8'ha5);
        push_code(8'h5a, 1'b1);
        run_stream();
        set_sizes(CNT_MAX, 2);
        gen_q.delete();
        push_code(8'hff);
        push_code(8'h11);
        push_code(8'h22);
        push_code(8'h33, 1'b1);
        run_stream();
    endtask

    // Receiver holds off while the sender keeps offering literals
    task automatic test_input_backpressure();
        gen_q.delete();
        repeat (8) begin
            push_code(lzr_pkg::FLAG_MARKER);
            repeat (8) push_code(lzr_pkg::t_byte'($urandom));
        end
        end_stream();
        set_sizes(64, CNT_MAX);
        no_gaps = 1'b1;
        rx_hold = RX_HOLD_CYCLES;
        run_stream();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_streams();
        int         start;
        int         ntok;
        int         n;
        int         r;
        t_cut       cut;
        t_size_mode mode;
        start = codes_sent;
        while (codes_sent - start < RANDOM_CODES) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0) begin
                // unstructured bytes
                gen_q.delete();
                repeat ($urandom_range(1, 24)) push_code(lzr_pkg::t_byte'($urandom));
                end_stream();
                set_sizes($urandom_range(0, 40),
                          ($urandom_range(0, 1) == 0) ? CNT_MAX
                                                      : lzr_pkg::t_cnt'($urandom_range(0, 40)));
            end else begin
                ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48)
                                                   : $urandom_range(1, 12);
                r = $urandom_range(0, 9);
                cut = (r == 0) ? CUT_AFTER_FLAG : (r == 1) ? CUT_AFTER_LOW : CUT_NONE;
                build_stream(ntok, cut);
                n = gen_count;
                mode = t_size_mode'($urandom_range(0, 5));
                case (mode)
                    SZ_EXACT:   set_sizes(n, ($urandom_range(0, 1) == 0) ? CNT_MAX
                                                : lzr_pkg::t_cnt'(n + $urandom_range(0, 3)));
                    SZ_SHORT:   set_sizes(n + $urandom_range(1, 40), CNT_MAX);
                    SZ_OVER:    set_sizes($urandom_range(0, n - 1), CNT_MAX);
                    SZ_PREFIX:  set_sizes(($urandom_range(0, 1) == 0) ? lzr_pkg::t_cnt'(n)
                                                                      : CNT_MAX,
                                          $urandom_range(0, n));
                    SZ_EXTREME: begin
                        if ($urandom_range(0, 1) == 0) set_sizes(CNT_MAX, CNT_MAX);
                        else set_sizes(0, 0);
                    end
                    default:    set_sizes(n, n);
                endcase
            end
            run_stream();
        end
        no_gaps = 1'b0;
    endtask

    // ---------------- sequence ----------------

    initial begin
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.in_byte  <= '0;
        in_if.in_last  <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= lzr_pkg::CFG_EXPECTED_SIZE;
        cfg_if.data    <= '0;
        reg_expected = '0;
        reg_prefix   = CNT_MAX;
        clear_stream();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_registers();
        test_token_kinds();
        test_short_streams();
        test_output_limit();
        test_input_backpressure();
        test_random_streams();

        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d streams, %0d compressed bytes, %0d results checked",
                 streams_run, codes_sent, results_seen);
        $display("  %0d status-only results, %0d with size_error set, %0d mismatches",
                 status_seen, size_err_seen, fails);
        if (fails == 0) begin
            $display("** lzss_ring_decompressor: PASSED **");
        end else begin
            $display("** lzss_ring_decompressor: FAILED **");
        end
        $finish;
    end

endmodule
